@@ rtl/core/owsm_pkg.sv @@
// ----------------------------------------------------------------------------
// owsm_pkg
// Shared constants and types for the three-wheel omni speed mixer.
// ----------------------------------------------------------------------------
package owsm_pkg;

  localparam int FRAC_BITS     = 13;
  localparam int ONE_Q         = 8192;
  localparam int QUOT_BITS     = 14;
  localparam int COEF_BITS     = 16;
  localparam int RADIUS_BITS   = 15;
  localparam int NUM_WHEELS    = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int REG_IDX_BITS  = 3;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_W0_COS = 3'd0,
    REG_W0_SIN = 3'd1,
    REG_W1_COS = 3'd2,
    REG_W1_SIN = 3'd3,
    REG_W2_COS = 3'd4,
    REG_W2_SIN = 3'd5,
    REG_RADIUS = 3'd6
  } owsm_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } owsm_queue_stat_t;

endpackage

@@ rtl/core/owsm_queue.sv @@
// ----------------------------------------------------------------------------
// owsm_queue
// Short first-in first-out queue between the front and the back pipelines.
// ----------------------------------------------------------------------------
module owsm_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output owsm_pkg::owsm_queue_stat_t   stat
);
  import owsm_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign pop_data   = entry[rd_ptr];
  assign stat.full  = (count == CNT_BITS'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

@@ rtl/core/owsm_front.sv @@
// ----------------------------------------------------------------------------
// owsm_front
// Holds the mounting coefficients, forms the three wheel sums, floors them,
// and picks the divisor that the back end scales by.
// ----------------------------------------------------------------------------
module owsm_front #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [owsm_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [owsm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [VALUE_BITS-1:0]           vel_x,
  input  logic signed [VALUE_BITS-1:0]           vel_y,
  input  logic signed [VALUE_BITS-1:0]           turn_rate,
  input  owsm_pkg::owsm_queue_stat_t             q_stat,
  output logic                                   push,
  output logic [(VALUE_BITS+5)*owsm_pkg::NUM_WHEELS+owsm_pkg::NUM_WHEELS
                +(VALUE_BITS+5)-1:0]             push_data
);
  import owsm_pkg::*;

  localparam int PW = VALUE_BITS + COEF_BITS;
  localparam int SW = PW + 2;
  localparam int MW = SW - FRAC_BITS;

  logic signed [COEF_BITS-1:0] cos_coef [NUM_WHEELS];
  logic signed [COEF_BITS-1:0] sin_coef [NUM_WHEELS];
  logic [RADIUS_BITS-1:0]      radius;

  logic v1, v2, v3, v4, v5;
  logic front_en;

  logic signed [PW-1:0] prod_c [NUM_WHEELS];
  logic signed [PW-1:0] prod_s [NUM_WHEELS];
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] sum    [NUM_WHEELS];
  logic [MW-1:0]        wv     [NUM_WHEELS];
  logic [MW-1:0]        mag3   [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg3;
  logic [MW-1:0]        mag4   [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg4;
  logic [MW-1:0]        max01;
  logic [MW-1:0]        max_all;
  logic [MW-1:0]        mag5   [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg5;
  logic [MW-1:0]        div5;

  // Coefficient registers, to be written by the user only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coef[0] <= 16'sd4096;
      sin_coef[0] <= 16'sd7094;
      cos_coef[1] <= -16'sd4096;
      sin_coef[1] <= 16'sd7094;
      cos_coef[2] <= -16'sd8192;
      sin_coef[2] <= 16'sd0;
      radius      <= 15'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_W0_COS: cos_coef[0] <= cfg_data;
        REG_W0_SIN: sin_coef[0] <= cfg_data;
        REG_W1_COS: cos_coef[1] <= cfg_data;
        REG_W1_SIN: sin_coef[1] <= cfg_data;
        REG_W2_COS: cos_coef[2] <= cfg_data;
        REG_W2_SIN: sin_coef[2] <= cfg_data;
        REG_RADIUS: radius      <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The whole front moves together unless its last item cannot enter the queue.
  assign front_en = !(v5 && q_stat.full);
  assign in_stall = !front_en;
  assign push     = v5 && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (front_en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Floor to Q7.13 is simply dropping the fraction bits of the signed sum.
  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      wv[w] = sum[w][SW-1:FRAC_BITS];
    end
  end

  assign max01   = (mag4[0] >= mag4[1]) ? mag4[0] : mag4[1];
  assign max_all = (max01 >= mag4[2]) ? max01 : mag4[2];

  always_ff @(posedge clk) begin
    if (front_en) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        prod_c[w] <= cos_coef[w] * vel_x;
        prod_s[w] <= sin_coef[w] * vel_y;
        sum[w]    <= SW'(prod_c[w]) + SW'(prod_s[w]) + SW'(prod_r);
        neg3[w]   <= wv[w][MW-1];
        mag3[w]   <= wv[w][MW-1] ? (~wv[w] + MW'(1)) : wv[w];
        mag4[w]   <= mag3[w];
        neg4[w]   <= neg3[w];
        mag5[w]   <= mag4[w];
        neg5[w]   <= neg4[w];
      end
      prod_r <= $signed({1'b0, radius}) * turn_rate;
      // Dividing by one unit leaves an unscaled wheel exactly as it is.
      div5   <= (max_all > MW'(ONE_Q)) ? max_all : MW'(ONE_Q);
    end
  end

  assign push_data = {div5, neg5, mag5[2], mag5[1], mag5[0]};

endmodule

@@ rtl/core/owsm_back.sv @@
// ----------------------------------------------------------------------------
// owsm_back
// Restoring divider pipeline, one quotient bit per stage, followed by the
// direction and duty output register.
// ----------------------------------------------------------------------------
module owsm_back #(
  parameter int VALUE_BITS = 16,
  parameter int DUTY_BITS  = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  owsm_pkg::owsm_queue_stat_t             q_stat,
  output logic                                   pop,
  input  logic [(VALUE_BITS+5)*owsm_pkg::NUM_WHEELS+owsm_pkg::NUM_WHEELS
                +(VALUE_BITS+5)-1:0]             pop_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   dir0,
  output logic [DUTY_BITS-1:0]                   duty0,
  output logic                                   dir1,
  output logic [DUTY_BITS-1:0]                   duty1,
  output logic                                   dir2,
  output logic [DUTY_BITS-1:0]                   duty2
);
  import owsm_pkg::*;

  localparam int MW   = VALUE_BITS + COEF_BITS + 2 - FRAC_BITS;
  localparam int NSTG = QUOT_BITS;
  localparam int PRW  = QUOT_BITS + DUTY_BITS;

  logic back_en;

  logic [MW-1:0]         h_rem [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] h_neg;
  logic [MW-1:0]         h_div;

  logic [NSTG-1:0]       st_vld;
  logic [MW-1:0]         st_rem [NSTG][NUM_WHEELS];
  logic [QUOT_BITS-1:0]  st_quo [NSTG][NUM_WHEELS];
  logic [NUM_WHEELS-1:0] st_neg [NSTG];
  logic [MW-1:0]         st_div [NSTG];

  logic [QUOT_BITS-1:0]  src_quo [NSTG][NUM_WHEELS];
  logic [NUM_WHEELS-1:0] src_neg [NSTG];
  logic [MW-1:0]         src_div [NSTG];
  logic [MW-1:0]         nxt_rem [NSTG][NUM_WHEELS];
  logic [QUOT_BITS-1:0]  nxt_quo [NSTG][NUM_WHEELS];

  logic [PRW-1:0]        duty_prod [NUM_WHEELS];
  logic                  dir_bit   [NUM_WHEELS];
  logic [DUTY_BITS-1:0]  duty_val  [NUM_WHEELS];

  assign back_en = !(out_valid && out_stall);
  assign pop     = back_en && !q_stat.empty;

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      h_rem[w] = pop_data[w*MW +: MW];
      h_neg[w] = pop_data[NUM_WHEELS*MW + w];
    end
    h_div = pop_data[NUM_WHEELS*MW + NUM_WHEELS +: MW];
  end

  // Stage 0 settles the top quotient bit (the dividend never exceeds the
  // divisor); every later stage shifts the remainder left by one bit.
  always_comb begin
    logic [MW:0] trial;
    logic        ge;
    trial = '0;
    ge    = 1'b0;
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        src_neg[s] = h_neg;
        src_div[s] = h_div;
      end else begin
        src_neg[s] = st_neg[s-1];
        src_div[s] = st_div[s-1];
      end
      for (int w = 0; w < NUM_WHEELS; w++) begin
        if (s == 0) begin
          src_quo[s][w] = '0;
          trial         = {1'b0, h_rem[w]};
        end else begin
          src_quo[s][w] = st_quo[s-1][w];
          trial         = {st_rem[s-1][w], 1'b0};
        end
        ge            = (trial >= {1'b0, src_div[s]});
        nxt_rem[s][w] = ge ? MW'(trial - {1'b0, src_div[s]}) : MW'(trial);
        nxt_quo[s][w] = {src_quo[s][w][QUOT_BITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld    <= '0;
      out_valid <= 1'b0;
    end else if (back_en) begin
      st_vld    <= {st_vld[NSTG-2:0], !q_stat.empty};
      out_valid <= st_vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      for (int s = 0; s < NSTG; s++) begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
          st_rem[s][w] <= nxt_rem[s][w];
          st_quo[s][w] <= nxt_quo[s][w];
        end
        st_neg[s] <= src_neg[s];
        st_div[s] <= src_div[s];
      end
    end
  end

  // Duty is |w| * (2^DUTY_BITS - 1) >> 13, done as a shift and a subtract.
  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      duty_prod[w] = {st_quo[NSTG-1][w], {DUTY_BITS{1'b0}}}
                   - PRW'(st_quo[NSTG-1][w]);
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        // A negative speed that scales down to zero counts as forward.
        dir_bit[w]  <= !st_neg[NSTG-1][w] || (st_quo[NSTG-1][w] == '0);
        duty_val[w] <= duty_prod[w][FRAC_BITS +: DUTY_BITS];
      end
    end
  end

  assign dir0  = dir_bit[0];
  assign duty0 = duty_val[0];
  assign dir1  = dir_bit[1];
  assign duty1 = duty_val[1];
  assign dir2  = dir_bit[2];
  assign duty2 = duty_val[2];

endmodule

@@ rtl/core/omni_wheel_speed_mixer.sv @@
// ----------------------------------------------------------------------------
// omni_wheel_speed_mixer
// Inverse kinematics for a three-wheel omni base: body velocity command in,
// per-wheel direction and PWM duty out.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  ------    ---------            -------
//  command   in_valid / in_stall  vel_x, vel_y, turn_rate (signed Q2.13)
//  wheels    out_valid/ out_stall dir0..dir2, duty0..duty2
//  config    cfg_we               cfg_index, cfg_data
//
// One item is accepted every cycle while in_stall is low. A result passes
// through five front stages (multiply, sum, floor, a delay stage and the
// maximum), the queue, and the fourteen stage restoring divider. A stall
// on the result side halts the back end at once; the front keeps taking
// items until the four-entry queue fills.
// Reset is synchronous and returns the coefficients to their defaults.
// ----------------------------------------------------------------------------
module omni_wheel_speed_mixer #(
  parameter int VALUE_BITS = 16,
  parameter int DUTY_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [owsm_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [owsm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VALUE_BITS-1:0]        vel_x,
  input  logic signed [VALUE_BITS-1:0]        vel_y,
  input  logic signed [VALUE_BITS-1:0]        turn_rate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                dir0,
  output logic [DUTY_BITS-1:0]                duty0,
  output logic                                dir1,
  output logic [DUTY_BITS-1:0]                duty1,
  output logic                                dir2,
  output logic [DUTY_BITS-1:0]                duty2
);
  import owsm_pkg::*;

  localparam int MW      = VALUE_BITS + COEF_BITS + 2 - FRAC_BITS;
  localparam int ENTRY_W = MW * NUM_WHEELS + NUM_WHEELS + MW;

  owsm_queue_stat_t   q_stat;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;

  owsm_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .turn_rate (turn_rate),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  owsm_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  owsm_back #(
    .VALUE_BITS (VALUE_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dir0      (dir0),
    .duty0     (duty0),
    .dir1      (dir1),
    .duty1     (duty1),
    .dir2      (dir2),
    .duty2     (duty2)
  );

endmodule

@@ test/tb_omni_wheel_speed_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_speed_mixer
// Drives body velocity commands into the three-wheel omni speed mixer and
// checks each wheel result, field by field, against an independent
// fixed-point prediction held with its own copy of the coefficient registers.
// Each channel idles at random in some phases; the coefficients change only while idle.
// ----------------------------------------------------------------------------
module tb_omni_wheel_speed_mixer;
  import owsm_pkg::*;

  localparam int VALUE_BITS  = 16;
  localparam int DUTY_BITS   = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 30;
  localparam longint DUTY_FULL = (64'sd1 << DUTY_BITS) - 1;
  // Index beyond the register file; writes to it must be ignored.
  localparam logic [REG_IDX_BITS-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [NUM_WHEELS-1:0]                dir;
    logic [NUM_WHEELS-1:0][DUTY_BITS-1:0] duty;
  } wheel_drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_BITS-1:0] vel_x = '0;
  logic signed [VALUE_BITS-1:0] vel_y = '0;
  logic signed [VALUE_BITS-1:0] turn_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic dir0, dir1, dir2;
  logic [DUTY_BITS-1:0] duty0, duty1, duty2;

  logic [CFG_DATA_BITS-1:0] mix_reg [0:6];
  wheel_drive_t wheel_expect_q [$];
  int mismatch_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  bit send_idle = 1'b1;
  bit sink_idle = 1'b1;

  omni_wheel_speed_mixer #(
    .VALUE_BITS(VALUE_BITS),
    .DUTY_BITS(DUTY_BITS)
  ) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .vel_x(vel_x), .vel_y(vel_y), .turn_rate(turn_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir0(dir0), .duty0(duty0), .dir1(dir1), .duty1(duty1),
    .dir2(dir2), .duty2(duty2)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Wheel speeds from one command under the current coefficients.
  function automatic wheel_drive_t mix_wheels(input logic signed [VALUE_BITS-1:0] vx,
                                              input logic signed [VALUE_BITS-1:0] vy,
                                              input logic signed [VALUE_BITS-1:0] om);
    wheel_drive_t drive;
    longint speed [NUM_WHEELS];
    longint sum;
    longint mag;
    longint peak;
    longint radius;
    peak = 0;
    radius = longint'(mix_reg[REG_RADIUS][RADIUS_BITS-1:0]);
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sum = longint'($signed(mix_reg[2*i])) * longint'(vx)
          + longint'($signed(mix_reg[2*i+1])) * longint'(vy)
          + radius * longint'(om);
      // Arithmetic shift of the exact sum floors towards minus infinity.
      speed[i] = sum >>> FRAC_BITS;
      mag = (speed[i] < 0) ? -speed[i] : speed[i];
      if (mag > peak) peak = mag;
    end
    if (peak > ONE_Q) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        mag = (speed[i] < 0) ? -speed[i] : speed[i];
        mag = (mag << FRAC_BITS) / peak;
        speed[i] = (speed[i] < 0) ? -mag : mag;
      end
    end
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag = (speed[i] < 0) ? -speed[i] : speed[i];
      if (mag > ONE_Q) mag = ONE_Q;
      drive.dir[i] = (speed[i] >= 0);
      drive.duty[i] = DUTY_BITS'((mag * DUTY_FULL) >> FRAC_BITS);
    end
    return drive;
  endfunction

  task automatic report_mismatch(input string what);
    $display("result %0d: %s", result_count, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    wheel_drive_t seen;
    wheel_drive_t want;
    if (!rst && out_valid && !out_stall) begin
      seen.dir = {dir2, dir1, dir0};
      seen.duty = {duty2, duty1, duty0};
      if (wheel_expect_q.size() == 0) begin
        report_mismatch("wheel item arrived with nothing outstanding");
      end else begin
        want = wheel_expect_q.pop_front();
        for (int i = 0; i < NUM_WHEELS; i++) begin
          if (seen.dir[i] !== want.dir[i])
            report_mismatch($sformatf("dir%0d is %b, want %b", i, seen.dir[i], want.dir[i]));
          if (seen.duty[i] !== want.duty[i])
            report_mismatch($sformatf("duty%0d is %0d, want %0d", i, seen.duty[i],
                                      want.duty[i]));
        end
      end
      result_count++;
    end
  end

  // Result side: a random stall before each item, or none when idling is off.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_command(input logic [VALUE_BITS-1:0] vx,
                              input logic [VALUE_BITS-1:0] vy,
                              input logic [VALUE_BITS-1:0] om);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_x <= vx;
    vel_y <= vy;
    turn_rate <= om;
    do @(posedge clk); while (in_stall);
    wheel_expect_q.push_back(mix_wheels($signed(vx), $signed(vy), $signed(om)));
  endtask

  // Stop sending and wait for the block to empty completely.
  task automatic settle();
    in_valid <= 1'b0;
    while (wheel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS)
      mix_reg[idx] = {1'b0, value[RADIUS_BITS-1:0]};
    else if (idx < REG_RADIUS)
      mix_reg[idx] = value;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_command(16'h0000, 16'h0000, 16'h0000);
    send_command(16'h7FFF, 16'h0000, 16'h0000);
    send_command(16'h8000, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h7FFF, 16'h0000);
    send_command(16'h0000, 16'h8000, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h7FFF);
    send_command(16'h0000, 16'h0000, 16'h8000);
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_command(16'h8000, 16'h8000, 16'h8000);
    // Well inside 1.0, so no wheel is rescaled.
    send_command(16'd4096, 16'd2048, 16'hFC18);
    send_command(16'd8192, 16'h0000, 16'h0000);
    // Tiny sums floor to minus two, minus one and zero on the three wheels.
    send_command(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(16'h5555, 16'hAAAA, 16'h5555);
    settle();
  endtask

  // One wheel dominates so that a tiny negative wheel rescales to zero and
  // must then read as forward with no duty.
  task automatic test_scaled_to_zero();
    write_reg(REG_W0_COS, 16'h7FFF);
    write_reg(REG_W0_SIN, 16'h0000);
    write_reg(REG_W1_COS, 16'hFFFF);
    write_reg(REG_W1_SIN, 16'h0000);
    write_reg(REG_W2_COS, 16'h0000);
    write_reg(REG_W2_SIN, 16'h0000);
    write_reg(REG_RADIUS, 16'h0000);
    send_command(16'h7FFF, 16'h0000, 16'h0000);
    send_command(16'h7FFF, 16'd12345, 16'hFFF9);
    send_command(16'h8000, 16'h0000, 16'h0000);
    send_command(16'h0001, 16'h0000, 16'h0000);
    settle();
  endtask

  // Most negative coefficients, a radius written with its spare top bit set,
  // and a write to an index past the register file.
  task automatic test_register_extremes();
    for (int r = REG_W0_COS; r < REG_RADIUS; r++) write_reg(REG_IDX_BITS'(r), 16'h8000);
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_NONE, 16'h1234);
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_command(16'h8000, 16'h8000, 16'h8000);
    send_command(16'h7FFF, 16'h8000, 16'h0001);
    send_command(16'h0000, 16'h0000, 16'h0000);
    settle();
  endtask

  function automatic logic [VALUE_BITS-1:0] draw_value(input bit narrow);
    logic [VALUE_BITS-1:0] v;
    if (narrow) begin
      v = VALUE_BITS'($urandom_range(0, 6000));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = VALUE_BITS'($urandom);
    end
    return v;
  endfunction

  task automatic test_random_commands();
    bit narrow_cfg;
    for (int phase = 0; phase < 6; phase++) begin
      narrow_cfg = (phase % 2 == 0);
      send_idle = (phase % 4 == 0) || (phase % 4 == 2) || (phase >= 4);
      sink_idle = (phase % 4 == 0) || (phase % 4 == 3) || (phase >= 4);
      for (int r = REG_W0_COS; r < REG_RADIUS; r++)
        write_reg(REG_IDX_BITS'(r), narrow_cfg ? draw_value(1'b1) : 16'($urandom));
      write_reg(REG_RADIUS, narrow_cfg ? 16'($urandom_range(0, 8192)) : 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_NONE, 16'($urandom));
      for (int n = 0; n < 75; n++)
        send_command(draw_value($urandom_range(0, 9) < 6), draw_value($urandom_range(0, 9) < 6),
                     draw_value($urandom_range(0, 9) < 6));
      settle();
    end
  endtask

  initial begin
    mix_reg = '{16'd4096, 16'd7094, 16'hF000, 16'd7094, 16'hE000, 16'd0, 16'd2048};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_scaled_to_zero();
    test_register_extremes();
    test_random_commands();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
